// ----- hdl/wpd_pkg.sv -----
// Shared types and constants for the window presence detector.
package wpd_pkg;

  localparam int unsigned TimeWidth     = 32;
  localparam int unsigned HeightWidth   = 16;
  localparam int unsigned RegWidth      = 16;
  localparam int unsigned IntervalWidth = 26;
  localparam int unsigned AddrWidth     = 4;
  localparam int unsigned DataWidth     = 32;
  localparam int unsigned MsPerSecond   = 1000;

  typedef enum logic [1:0] {
    REG_LOW_LIMIT         = 2'd0,
    REG_HIGH_LIMIT        = 2'd1,
    REG_MIN_STABLE_MS     = 2'd2,
    REG_REPORT_INTERVAL_S = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [RegWidth-1:0]      low_limit;
    logic [RegWidth-1:0]      high_limit;
    logic [RegWidth-1:0]      min_stable_ms;
    logic                     periodic_en;
    logic [IntervalWidth-1:0] interval_ms;
  } cfg_t;

  typedef struct packed {
    logic present;
    logic stable;
    logic report_due;
  } result_t;

endpackage

// ----- hdl/wpd_if.sv -----
// Valid/ready channel interfaces for sample and result beats.
interface wpd_sample_if
  import wpd_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [TimeWidth-1:0]   timestamp_ms;
  logic [HeightWidth-1:0] height;

  modport source (output valid, output timestamp_ms, output height, input ready);
  modport sink (input valid, input timestamp_ms, input height, output ready);
endinterface

interface wpd_result_if;
  logic valid;
  logic ready;
  logic present;
  logic stable;
  logic report_due;

  modport source (output valid, output present, output stable, output report_due,
                  input ready);
  modport sink (input valid, input present, input stable, input report_due,
                output ready);
endinterface

// ----- hdl/window_presence_detector_core.sv -----
// Top level of the window presence detector: sample register, evaluation, result register.
//
// Usage:
//   The sample channel takes one beat per sensor reading (timestamp_ms, height).
//   The result channel gives exactly one beat per sample: present, stable and
//   report_due, in sample order.
//   Configuration registers sit on the APB port: low_limit at 0x0, high_limit
//   at 0x4, min_stable_ms at 0x8, report_interval_s at 0xC. Write them only
//   while no sample is in flight.
//   Order: a sample beat is accepted into the sample register; its result is
//   evaluated from there and loaded into the result register, which drives
//   the result beat. Throughput: one sample per cycle unless the result
//   channel stalls; the window compare and the two 32-bit elapsed-time
//   compares sit in the single stage between the registers.
//   Reset: clears both stage valids, the presence and stable history, the
//   change and report times, and loads the register defaults.
//   Stall: while the result beat waits, the sample register fills and holds;
//   sample ready drops only when both stages are full.
module window_presence_detector_core
  import wpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  wpd_sample_if.sink           sample,
  wpd_result_if.source         result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t                   cfg;
  logic                   in_valid;
  logic [TimeWidth-1:0]   in_timestamp_ms;
  logic [HeightWidth-1:0] in_height;
  logic                   out_valid;
  result_t                out_res;
  result_t                res;
  logic                   advance;

  wpd_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wpd_detect u_detect (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .advance      (advance),
    .timestamp_ms (in_timestamp_ms),
    .height       (in_height),
    .res          (res)
  );

  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      in_timestamp_ms <= sample.timestamp_ms;
      in_height       <= sample.height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign result.valid      = out_valid;
  assign result.present    = out_res.present;
  assign result.stable     = out_res.stable;
  assign result.report_due = out_res.report_due;

endmodule

// ----- hdl/wpd_cfg_regs.sv -----
// APB configuration registers for the window presence detector.
module wpd_cfg_regs
  import wpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic [RegWidth-1:0]      low_limit;
  logic [RegWidth-1:0]      high_limit;
  logic [RegWidth-1:0]      min_stable_ms;
  logic [RegWidth-1:0]      report_interval_s;
  logic [IntervalWidth-1:0] interval_ms;
  logic [RegWidth-1:0]      wdata;
  reg_index_t               index;
  logic                     wr_en;

  assign pready = 1'b1;
  assign index  = reg_index_t'(paddr[AddrWidth-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign wdata  = pwdata[RegWidth-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit         <= '0;
      high_limit        <= '1;
      min_stable_ms     <= '0;
      report_interval_s <= '0;
      interval_ms       <= '0;
    end else if (wr_en) begin
      unique case (index)
        REG_LOW_LIMIT:         low_limit     <= wdata;
        REG_HIGH_LIMIT:        high_limit    <= wdata;
        REG_MIN_STABLE_MS:     min_stable_ms <= wdata;
        REG_REPORT_INTERVAL_S: begin
          report_interval_s <= wdata;
          interval_ms       <= IntervalWidth'(IntervalWidth'(wdata) * MsPerSecond);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      REG_LOW_LIMIT:         prdata[RegWidth-1:0] = low_limit;
      REG_HIGH_LIMIT:        prdata[RegWidth-1:0] = high_limit;
      REG_MIN_STABLE_MS:     prdata[RegWidth-1:0] = min_stable_ms;
      REG_REPORT_INTERVAL_S: prdata[RegWidth-1:0] = report_interval_s;
      default:               prdata = '0;
    endcase
  end

  assign cfg.low_limit     = low_limit;
  assign cfg.high_limit    = high_limit;
  assign cfg.min_stable_ms = min_stable_ms;
  assign cfg.periodic_en   = report_interval_s != '0;
  assign cfg.interval_ms   = interval_ms;

endmodule

// ----- hdl/wpd_detect.sv -----
// Window compare, stability tracking and report timing for one sample.
module wpd_detect
  import wpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   advance,
  input  logic [TimeWidth-1:0]   timestamp_ms,
  input  logic [HeightWidth-1:0] height,
  output result_t                res
);

  logic                 prev_present;
  logic                 stable_flag;
  logic [TimeWidth-1:0] change_time;
  logic [TimeWidth-1:0] report_time;

  logic                 present;
  logic                 changed;
  logic                 stable_prior;
  logic [TimeWidth-1:0] change_elapsed;
  logic [TimeWidth-1:0] report_elapsed;
  logic                 entered;
  logic                 periodic;
  logic                 due;

  always_comb begin
    present        = (height >= cfg.low_limit) && (height <= cfg.high_limit);
    changed        = present != prev_present;
    stable_prior   = stable_flag && !changed;
    change_elapsed = changed ? '0 : timestamp_ms - change_time;
    entered        = !stable_prior && (change_elapsed >= TimeWidth'(cfg.min_stable_ms));
    report_elapsed = timestamp_ms - report_time;
    periodic       = cfg.periodic_en && (report_elapsed >= TimeWidth'(cfg.interval_ms));
    due            = entered || periodic;
  end

  assign res.present    = present;
  assign res.stable     = stable_prior || entered;
  assign res.report_due = due;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_present <= 1'b0;
      stable_flag  <= 1'b0;
      change_time  <= '0;
      report_time  <= '0;
    end else if (advance) begin
      prev_present <= present;
      stable_flag  <= stable_prior || entered;
      if (changed) begin
        change_time <= timestamp_ms;
      end
      if (due) begin
        report_time <= timestamp_ms;
      end
    end
  end

endmodule
